### hw/rtl/blm_pkg.sv
// Shared types, constants and the charge curve for the battery level monitor.
// Used by every module under hw/rtl; no dependencies of its own.
package blm_pkg;

  localparam int SUM_W        = 15;
  localparam int MV_W         = 14;
  localparam int PCT_W        = 10;
  localparam int HYST_W       = 10;

  localparam int ADC_SAMPLES  = 8;
  // power of two: the average is a shift of the running sum
  localparam int FILTER_DEPTH = 8;
  localparam int IDX_W        = $clog2(FILTER_DEPTH);
  localparam int ACC_W        = MV_W + IDX_W;

  localparam int MV_NUM       = 103191;
  localparam int MV_DEN       = 40950 * ADC_SAMPLES;
  localparam int MV_MAX       = 16383;
  localparam int GUARD_MV     = 3000;

  // floor(sum * MV_NUM / MV_DEN) by reciprocal estimate plus one correction step
  localparam int RECIP_SH = 32;
  localparam longint unsigned MV_RECIP =
      (longint'(MV_NUM) << RECIP_SH) / longint'(MV_DEN);
  localparam int RECIP_W = $clog2(MV_RECIP + 1);
  localparam int NUM_W   = $clog2(MV_NUM + 1);
  localparam int DEN_W   = $clog2(MV_DEN + 1);
  localparam int PROD_W  = SUM_W + NUM_W;
  localparam int EST_W   = SUM_W + RECIP_W;
  localparam int RAW_W   = EST_W - RECIP_SH;
  localparam int QB_W    = RAW_W + DEN_W;

  localparam logic [MV_W-1:0]   WARN_RST   = MV_W'(7000);
  localparam logic [MV_W-1:0]   CRIT_RST   = MV_W'(6400);
  localparam logic [MV_W-1:0]   CUTOFF_RST = MV_W'(6000);
  localparam logic [HYST_W-1:0] HYST_RST   = HYST_W'(150);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WARN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CRIT   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUTOFF = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_HYST   = 2'd3;

  typedef enum logic [1:0] {
    LVL_NORMAL,
    LVL_WARNING,
    LVL_CRITICAL,
    LVL_SHUTDOWN
  } level_t;

  typedef struct packed {
    logic [MV_W-1:0]   warn_mv;
    logic [MV_W-1:0]   crit_mv;
    logic [MV_W-1:0]   cutoff_mv;
    logic [HYST_W-1:0] hysteresis_mv;
  } thresh_t;

  typedef struct packed {
    logic [MV_W-1:0] avg;
    logic            accepted;
    logic            check;
  } filt_t;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [PCT_W-1:0] percent_tenths;
    level_t           level;
    logic             accepted;
    logic             level_changed;
    logic             emergency;
  } result_t;

  // breakpoints in mV and tenths; each segment slope is CURVE_MUL / 2**CURVE_SHIFT
  localparam logic [MV_W-1:0] CURVE_MV [6] =
      '{14'd6000, 14'd6400, 14'd7000, 14'd7400, 14'd8200, 14'd8400};
  localparam logic [PCT_W-1:0] CURVE_PT [6] =
      '{10'd0, 10'd50, 10'd200, 10'd500, 10'd900, 10'd1000};
  localparam logic [1:0] CURVE_MUL   [5] = '{2'd1, 2'd1, 2'd3, 2'd1, 2'd1};
  localparam logic [1:0] CURVE_SHIFT [5] = '{2'd3, 2'd2, 2'd2, 2'd1, 2'd1};

  function automatic logic [PCT_W-1:0] mv_to_tenths(input logic [MV_W-1:0] v);
    logic [MV_W-1:0]  d;
    logic [15:0]      t;
    logic             found;
    logic [PCT_W-1:0] res;
    res   = '0;
    found = 1'b0;
    d     = '0;
    t     = '0;
    if (v <= CURVE_MV[0]) begin
      res = CURVE_PT[0];
    end else if (v >= CURVE_MV[5]) begin
      res = CURVE_PT[5];
    end else begin
      for (int i = 0; i < 5; i++) begin
        if (!found && v <= CURVE_MV[i+1]) begin
          d     = v - CURVE_MV[i];
          t     = (16'(d) * 16'(CURVE_MUL[i])) >> CURVE_SHIFT[i];
          res   = CURVE_PT[i] + t[PCT_W-1:0];
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/blm_scale.sv
// Four-stage pipeline that converts an ADC sum to battery millivolts.
// Depends on blm_pkg for widths and the scaling reciprocal.
module blm_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [blm_pkg::SUM_W-1:0]     in_adc_sum,
  output logic                          mv_valid,
  output logic [blm_pkg::MV_W-1:0]      mv
);

  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [blm_pkg::SUM_W-1:0]     sum1_r;
  logic [blm_pkg::EST_W-1:0]     est2_r;
  logic [blm_pkg::PROD_W-1:0]    sa2_r;
  logic [blm_pkg::PROD_W-1:0]    sa3_r;
  logic [blm_pkg::PROD_W-1:0]    qb3_r;
  logic [blm_pkg::RAW_W-1:0]     q3_r;
  logic [blm_pkg::MV_W-1:0]      mv4_r;

  logic [blm_pkg::RAW_W-1:0]     q_est;
  logic [blm_pkg::QB_W-1:0]      qb_full;
  logic [blm_pkg::PROD_W-1:0]    rem;
  logic                          corr;
  logic [blm_pkg::RAW_W:0]       mv_raw;
  logic [blm_pkg::MV_W-1:0]      mv4_nxt;

  assign q_est   = est2_r[blm_pkg::EST_W-1:blm_pkg::RECIP_SH];
  assign qb_full = blm_pkg::QB_W'(q_est) * blm_pkg::QB_W'(blm_pkg::MV_DEN);

  always_comb begin
    rem    = sa3_r - qb3_r;
    corr   = (rem >= blm_pkg::PROD_W'(blm_pkg::MV_DEN));
    mv_raw = (blm_pkg::RAW_W+1)'(q3_r) + (blm_pkg::RAW_W+1)'(corr);
    if (mv_raw > (blm_pkg::RAW_W+1)'(blm_pkg::MV_MAX)) begin
      mv4_nxt = blm_pkg::MV_W'(blm_pkg::MV_MAX);
    end else begin
      mv4_nxt = blm_pkg::MV_W'(mv_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1_r <= in_adc_sum;
      est2_r <= blm_pkg::EST_W'(sum1_r) * blm_pkg::EST_W'(blm_pkg::MV_RECIP);
      sa2_r  <= blm_pkg::PROD_W'(sum1_r) * blm_pkg::PROD_W'(blm_pkg::MV_NUM);
      q3_r   <= q_est;
      qb3_r  <= qb_full[blm_pkg::PROD_W-1:0];
      sa3_r  <= sa2_r;
      mv4_r  <= mv4_nxt;
    end
  end

  assign mv_valid = v4_r;
  assign mv       = mv4_r;

endmodule

### hw/rtl/blm_filter.sv
// Moving-average ring with running sum, priming on the first item and low-sample guard.
// Depends on blm_pkg for the filter depth and the filt_t stage record.
module blm_filter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      mv_valid,
  input  logic [blm_pkg::MV_W-1:0]  mv,
  output logic                      filt_valid,
  output blm_pkg::filt_t            filt
);

  logic [blm_pkg::MV_W-1:0]   ring_r [blm_pkg::FILTER_DEPTH];
  logic [blm_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [blm_pkg::ACC_W-1:0]  sum_r, sum_nxt;
  logic                       primed_r, primed_nxt;
  logic                       valid_r;
  blm_pkg::filt_t             filt_r, filt_nxt;

  logic                       take;
  logic                       fill;
  logic                       push;

  assign take = en && mv_valid;

  always_comb begin
    fill       = 1'b0;
    push       = 1'b0;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    primed_nxt = primed_r;
    filt_nxt   = '0;
    if (!primed_r) begin
      fill              = 1'b1;
      sum_nxt           = {mv, {blm_pkg::IDX_W{1'b0}}};
      idx_nxt           = '0;
      primed_nxt        = 1'b1;
      filt_nxt.accepted = 1'b1;
    end else if (mv >= blm_pkg::MV_W'(blm_pkg::GUARD_MV)) begin
      push    = 1'b1;
      sum_nxt = sum_r - blm_pkg::ACC_W'(ring_r[idx_r]) + blm_pkg::ACC_W'(mv);
      if (idx_r == blm_pkg::IDX_W'(blm_pkg::FILTER_DEPTH - 1)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
      filt_nxt.accepted = 1'b1;
      filt_nxt.check    = 1'b1;
    end
    filt_nxt.avg = sum_nxt[blm_pkg::ACC_W-1:blm_pkg::IDX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      sum_r    <= '0;
      primed_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      if (en) begin
        valid_r <= mv_valid;
      end
      if (take) begin
        idx_r    <= idx_nxt;
        sum_r    <= sum_nxt;
        primed_r <= primed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      filt_r <= filt_nxt;
      if (fill) begin
        for (int i = 0; i < blm_pkg::FILTER_DEPTH; i++) begin
          ring_r[i] <= mv;
        end
      end else if (push) begin
        ring_r[idx_r] <= mv;
      end
    end
  end

  assign filt_valid = valid_r;
  assign filt       = filt_r;

endmodule

### hw/rtl/blm_level.sv
// Hysteresis level state machine, charge curve and the result register.
// Depends on blm_pkg for level_t, thresh_t, filt_t, result_t and mv_to_tenths.
module blm_level (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  blm_pkg::thresh_t    thr,
  input  logic                filt_valid,
  input  blm_pkg::filt_t      filt,
  output logic                res_valid,
  output blm_pkg::result_t    res
);

  blm_pkg::level_t            level_r, level_nxt;
  logic                       emergency;
  logic                       out_valid_r;
  blm_pkg::result_t           res_r;
  logic [blm_pkg::MV_W:0]     warn_up;
  logic [blm_pkg::MV_W:0]     crit_up;

  assign warn_up = (blm_pkg::MV_W+1)'(thr.warn_mv)
                 + (blm_pkg::MV_W+1)'(thr.hysteresis_mv);
  assign crit_up = (blm_pkg::MV_W+1)'(thr.crit_mv)
                 + (blm_pkg::MV_W+1)'(thr.hysteresis_mv);

  always_comb begin
    level_nxt = level_r;
    emergency = 1'b0;
    if (filt.check) begin
      case (level_r)
        blm_pkg::LVL_NORMAL: begin
          if (filt.avg < thr.warn_mv) level_nxt = blm_pkg::LVL_WARNING;
        end
        blm_pkg::LVL_WARNING: begin
          if ((blm_pkg::MV_W+1)'(filt.avg) > warn_up) begin
            level_nxt = blm_pkg::LVL_NORMAL;
          end else if (filt.avg < thr.crit_mv) begin
            level_nxt = blm_pkg::LVL_CRITICAL;
          end
        end
        blm_pkg::LVL_CRITICAL: begin
          if ((blm_pkg::MV_W+1)'(filt.avg) > crit_up) begin
            level_nxt = blm_pkg::LVL_WARNING;
          end else if (filt.avg < thr.cutoff_mv) begin
            level_nxt = blm_pkg::LVL_SHUTDOWN;
            emergency = 1'b1;
          end
        end
        default: begin
          level_nxt = level_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= blm_pkg::LVL_NORMAL;
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= filt_valid;
      if (filt_valid) level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && filt_valid) begin
      res_r.voltage_mv     <= filt.avg;
      res_r.percent_tenths <= blm_pkg::mv_to_tenths(filt.avg);
      res_r.level          <= level_nxt;
      res_r.accepted       <= filt.accepted;
      res_r.level_changed  <= (level_nxt != level_r);
      res_r.emergency      <= emergency;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

### hw/rtl/battery_level_monitor.sv
// Battery level monitor top level: APB threshold registers, scaling pipeline,
// moving-average filter and level/charge stage; depends on blm_pkg and all blm_ modules.
// The input register loads at the accept edge, then three scaling stages, the filter stage
// and the result stage follow before the result is valid.
// Throughput: one item per cycle; the whole pipeline and in_ready hold while a result waits.
// Synchronous reset on rst_n low: default thresholds, empty pipeline, unprimed filter, normal.
module battery_level_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blm_pkg::SUM_W-1:0]     in_adc_sum,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blm_pkg::MV_W-1:0]      out_voltage_mv,
  output logic [blm_pkg::PCT_W-1:0]     out_percent_tenths,
  output logic [1:0]                    out_level,
  output logic                          out_accepted,
  output logic                          out_level_changed,
  output logic                          out_emergency,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  blm_pkg::thresh_t                 thr_r;
  logic                             en;
  logic                             mv_valid;
  logic [blm_pkg::MV_W-1:0]         mv;
  logic                             filt_valid;
  blm_pkg::filt_t                   filt;
  logic                             res_valid;
  blm_pkg::result_t                 res;
  logic [blm_pkg::REG_IDX_W-1:0]    reg_idx;

  assign en       = !res_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;
  assign reg_idx  = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.warn_mv       <= blm_pkg::WARN_RST;
      thr_r.crit_mv       <= blm_pkg::CRIT_RST;
      thr_r.cutoff_mv     <= blm_pkg::CUTOFF_RST;
      thr_r.hysteresis_mv <= blm_pkg::HYST_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        blm_pkg::REG_WARN:   thr_r.warn_mv       <= pwdata[blm_pkg::MV_W-1:0];
        blm_pkg::REG_CRIT:   thr_r.crit_mv       <= pwdata[blm_pkg::MV_W-1:0];
        blm_pkg::REG_CUTOFF: thr_r.cutoff_mv     <= pwdata[blm_pkg::MV_W-1:0];
        blm_pkg::REG_HYST:   thr_r.hysteresis_mv <= pwdata[blm_pkg::HYST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      blm_pkg::REG_WARN:   prdata = 32'(thr_r.warn_mv);
      blm_pkg::REG_CRIT:   prdata = 32'(thr_r.crit_mv);
      blm_pkg::REG_CUTOFF: prdata = 32'(thr_r.cutoff_mv);
      blm_pkg::REG_HYST:   prdata = 32'(thr_r.hysteresis_mv);
      default:             prdata = '0;
    endcase
  end

  blm_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_adc_sum (in_adc_sum),
    .mv_valid   (mv_valid),
    .mv         (mv)
  );

  blm_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .mv_valid   (mv_valid),
    .mv         (mv),
    .filt_valid (filt_valid),
    .filt       (filt)
  );

  blm_level u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .thr        (thr_r),
    .filt_valid (filt_valid),
    .filt       (filt),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid          = res_valid;
  assign out_voltage_mv     = res.voltage_mv;
  assign out_percent_tenths = res.percent_tenths;
  assign out_level          = res.level;
  assign out_accepted       = res.accepted;
  assign out_level_changed  = res.level_changed;
  assign out_emergency      = res.emergency;

endmodule
